>>> rtl/core/pwlc_pkg.sv
// Shared types, constants and the color ramp table for the piecewise-linear colormap.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package pwlc_pkg;

    // Field widths
    localparam int SCALAR_W  = 16;
    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 3 * CHAN_W;
    localparam int RGBA_W    = 4 * CHAN_W;
    localparam int CFG_IDX_W = 3;

    // Register index map
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_LAST   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_MODE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_COLOR = 3'd7;
    localparam int                   NUM_BREAKS       = 6;

    // Reset values
    localparam logic signed [SCALAR_W-1:0] BREAK_RESET      = 16'sd0;
    localparam logic signed [SCALAR_W-1:0] BREAK_LAST_RESET = 16'sd256;
    localparam logic [RGBA_W-1:0]          SINGLE_RESET     = 32'h8000_00FF;

    // How the color of an item is chosen
    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_LOW    = 2'd1;
    localparam logic [1:0] KIND_HIGH   = 2'd2;
    localparam logic [1:0] KIND_SEG    = 2'd3;

    // Divider geometry: rem = 2*v + den, divisor = 2*den, quotient never above 255
    localparam int NUM_W          = 26;
    localparam int DVS_W          = 17;
    localparam int QUO_W          = CHAN_W;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DVS_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
    } div_t;

    // Side data that rides along the divider stages
    typedef struct packed {
        logic               use_div;
        logic [COLOR_W-1:0] fix;
    } meta_t;

    // Six-entry ramp, packed {R,G,B}: blue, cyan, green, yellow, orange, red
    function automatic logic [COLOR_W-1:0] ramp_color(input logic [2:0] idx);
        logic [COLOR_W-1:0] c;
        begin
            case (idx)
                3'd0:    c = 24'h0000FF;
                3'd1:    c = 24'h00FFFF;
                3'd2:    c = 24'h00FF00;
                3'd3:    c = 24'hFFFF00;
                3'd4:    c = 24'hFF8000;
                3'd5:    c = 24'hFF0000;
                default: c = 24'h000000;
            endcase
            ramp_color = c;
        end
    endfunction

endpackage

>>> rtl/core/pwlc_div_stage.sv
// One registered stage of the restoring divider: resolves two quotient bits.
// Depends on pwlc_pkg for div_t and the divider geometry.
module pwlc_div_stage #(
    parameter int STAGE = 0
) (
    input  logic          clk,
    input  logic          en,
    input  pwlc_pkg::div_t d,
    output pwlc_pkg::div_t q
);

    localparam int TOP_BIT = pwlc_pkg::QUO_W - 1 - pwlc_pkg::BITS_PER_STAGE * STAGE;

    pwlc_pkg::div_t q_reg;
    pwlc_pkg::div_t q_next;

    // Compare against the shifted divisor, subtract on success
    always_comb
    begin
        logic [pwlc_pkg::NUM_W-1:0] trial;
        q_next = d;
        for (int j = 0; j < pwlc_pkg::BITS_PER_STAGE; j++)
        begin
            trial = pwlc_pkg::NUM_W'(d.dvs) << (TOP_BIT - j);
            if (q_next.rem >= trial)
            begin
                q_next.rem = q_next.rem - trial;
                q_next.quo[TOP_BIT-j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

>>> rtl/core/piecewise_linear_colormap_top.sv
// Top level of the piecewise-linear colormap: config registers, segment search,
// interpolation products and the divider pipeline. Depends on pwlc_pkg, pwlc_div_stage.

// The block turns one signed Q8.8 scalar per transfer into an 8-bit RGBA color. It takes
// one item every cycle while the output is not stalled: one stage compares the scalar with
// all breakpoints, one forms the segment offset and width, one forms the interpolation
// products, four resolve the rounded quotient two bits at a time, and one holds the
// result. A stall on the output freezes the whole pipeline, so in_ready follows out_ready
// whenever a result is waiting. Configuration writes are always taken and
// must only be issued while no item is in flight; alpha always reflects the current
// single-color register.
module piecewise_linear_colormap_top #(
    parameter int MAP_POINTS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [15:0] scalar,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha
);

    localparam int LAST  = MAP_POINTS - 1;
    localparam int SEG_W = $clog2(MAP_POINTS);
    localparam int CW    = pwlc_pkg::CHAN_W;
    localparam int DS    = pwlc_pkg::DIV_STAGES;

    // ---------------- configuration registers ----------------
    logic signed [15:0] brk_reg [0:pwlc_pkg::NUM_BREAKS-1];
    logic               map_mode_reg;
    logic [31:0]        single_color_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < pwlc_pkg::NUM_BREAKS; k++)
            begin
                brk_reg[k] <= pwlc_pkg::BREAK_RESET;
            end
            brk_reg[pwlc_pkg::NUM_BREAKS-1] <= pwlc_pkg::BREAK_LAST_RESET;
            map_mode_reg     <= 1'b0;
            single_color_reg <= pwlc_pkg::SINGLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int k = 0; k < pwlc_pkg::NUM_BREAKS; k++)
            begin
                if (cfg_index == pwlc_pkg::CFG_IDX_W'(k))
                begin
                    brk_reg[k] <= cfg_data[15:0];
                end
            end
            if (cfg_index == pwlc_pkg::REG_MAP_MODE)
            begin
                map_mode_reg <= cfg_data[0];
            end
            if (cfg_index == pwlc_pkg::REG_SINGLE_COLOR)
            begin
                single_color_reg <= cfg_data;
            end
        end
    end

    // Global pipeline advance: everything moves when the output slot is free or drains
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // ---------------- stage A: classify and search ----------------
    logic                a_valid_reg;
    logic signed [15:0]  a_scalar_reg;
    logic [1:0]          a_kind_reg;
    logic [SEG_W-1:0]    a_seg_reg;
    logic [23:0]         a_fix_reg;
    logic [1:0]          a_kind_next;
    logic [SEG_W-1:0]    a_seg_next;
    logic [23:0]         a_fix_next;

    always_comb
    begin
        // first breakpoint above the scalar, falling back to the last segment
        a_seg_next = SEG_W'(LAST);
        for (int k = LAST; k >= 1; k--)
        begin
            if (scalar < brk_reg[k])
            begin
                a_seg_next = SEG_W'(k);
            end
        end

        if (!map_mode_reg)
        begin
            a_kind_next = pwlc_pkg::KIND_SINGLE;
            a_fix_next  = single_color_reg[31:8];
        end
        else if (scalar <= brk_reg[0])
        begin
            a_kind_next = pwlc_pkg::KIND_LOW;
            a_fix_next  = pwlc_pkg::ramp_color(3'd0);
        end
        else if (scalar >= brk_reg[LAST])
        begin
            a_kind_next = pwlc_pkg::KIND_HIGH;
            a_fix_next  = pwlc_pkg::ramp_color(3'(LAST));
        end
        else
        begin
            a_kind_next = pwlc_pkg::KIND_SEG;
            a_fix_next  = '0;
        end
    end

    // ---------------- stage B: segment offset and width ----------------
    logic               b_valid_reg;
    logic [15:0]        b_num_reg;
    logic [15:0]        b_den_reg;
    logic [SEG_W-1:0]   b_seg_reg;
    logic               b_use_div_reg;
    logic [23:0]        b_fix_reg;
    logic signed [16:0] b_num17_next;
    logic signed [16:0] b_den17_next;
    logic               b_den_ok;
    logic [23:0]        b_fix_next;

    always_comb
    begin
        b_num17_next = '0;
        b_den17_next = '0;
        for (int k = 1; k <= LAST; k++)
        begin
            if (a_seg_reg == SEG_W'(k))
            begin
                b_num17_next = {a_scalar_reg[15], a_scalar_reg}
                             - {brk_reg[k-1][15], brk_reg[k-1]};
                b_den17_next = {brk_reg[k][15], brk_reg[k]}
                             - {brk_reg[k-1][15], brk_reg[k-1]};
            end
        end
        b_den_ok = !b_den17_next[16] && (b_den17_next != 17'sd0);

        // a non-positive segment width falls back to the lower ramp color
        if (a_kind_reg == pwlc_pkg::KIND_SEG)
        begin
            b_fix_next = pwlc_pkg::ramp_color(3'(a_seg_reg) - 3'd1);
        end
        else
        begin
            b_fix_next = a_fix_reg;
        end
    end

    // ---------------- stage C: interpolation products ----------------
    logic                c_valid_reg;
    pwlc_pkg::div_t      c_div_reg  [0:2];
    pwlc_pkg::div_t      c_div_next [0:2];
    pwlc_pkg::meta_t     c_meta_next;

    always_comb
    begin
        logic [23:0] col_lo;
        logic [23:0] col_hi;
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [15:0] w0;
        logic [23:0] p0;
        logic [23:0] p1;
        logic [24:0] v;
        col_lo = pwlc_pkg::ramp_color(3'(b_seg_reg) - 3'd1);
        col_hi = pwlc_pkg::ramp_color(3'(b_seg_reg));
        w0     = b_den_reg - b_num_reg;
        for (int ch = 0; ch < 3; ch++)
        begin
            c0 = col_lo[23-CW*ch -: CW];
            c1 = col_hi[23-CW*ch -: CW];
            // v = c0*(den-num) + c1*num, never negative
            p0 = {16'b0, c0} * {8'b0, w0};
            p1 = {16'b0, c1} * {8'b0, b_num_reg};
            v  = {1'b0, p0} + {1'b0, p1};
            c_div_next[ch].rem = {v, 1'b0} + {10'b0, b_den_reg};
            c_div_next[ch].dvs = {b_den_reg, 1'b0};
            c_div_next[ch].quo = '0;
        end
        c_meta_next.use_div = b_use_div_reg;
        c_meta_next.fix     = b_fix_reg;
    end

    // ---------------- divider pipeline ----------------
    // d_valid_reg[i] travels with div_pipe[i+1]
    logic [DS-1:0]   d_valid_reg;
    pwlc_pkg::meta_t meta_reg [0:DS];
    pwlc_pkg::div_t  div_pipe [0:DS][0:2];

    genvar gs, gc;
    generate
        for (gc = 0; gc < 3; gc++)
        begin : g_chan_in
            assign div_pipe[0][gc] = c_div_reg[gc];
        end
        for (gs = 0; gs < DS; gs++)
        begin : g_stage
            for (gc = 0; gc < 3; gc++)
            begin : g_chan
                pwlc_div_stage #(
                    .STAGE (gs)
                ) u_div (
                    .clk (clk),
                    .en  (adv),
                    .d   (div_pipe[gs][gc]),
                    .q   (div_pipe[gs+1][gc])
                );
            end
        end
    endgenerate

    // ---------------- output stage ----------------
    logic [23:0] out_color_reg;
    logic [23:0] out_color_next;

    always_comb
    begin
        if (meta_reg[DS].use_div)
        begin
            out_color_next = {div_pipe[DS][0].quo, div_pipe[DS][1].quo,
                              div_pipe[DS][2].quo};
        end
        else
        begin
            out_color_next = meta_reg[DS].fix;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= {d_valid_reg[DS-2:0], c_valid_reg};
            out_valid_reg <= d_valid_reg[DS-1];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_scalar_reg  <= scalar;
            a_kind_reg    <= a_kind_next;
            a_seg_reg     <= a_seg_next;
            a_fix_reg     <= a_fix_next;

            b_num_reg     <= b_num17_next[15:0];
            b_den_reg     <= b_den17_next[15:0];
            b_seg_reg     <= a_seg_reg;
            b_use_div_reg <= (a_kind_reg == pwlc_pkg::KIND_SEG) && b_den_ok;
            b_fix_reg     <= b_fix_next;

            for (int ch = 0; ch < 3; ch++)
            begin
                c_div_reg[ch] <= c_div_next[ch];
            end
            meta_reg[0] <= c_meta_next;
            for (int s = 1; s <= DS; s++)
            begin
                meta_reg[s] <= meta_reg[s-1];
            end

            out_color_reg <= out_color_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = out_color_reg[23:16];
    assign green     = out_color_reg[15:8];
    assign blue      = out_color_reg[7:0];
    assign alpha     = single_color_reg[7:0];

    // ---------------- assertions ----------------
    // single mode passes the stored color straight through
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !map_mode_reg |-> out_color_reg == single_color_reg[31:8])
        else $error("single mode color mismatch");

    // a segment found by the search never has index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && a_kind_reg == pwlc_pkg::KIND_SEG |-> a_seg_reg != '0)
        else $error("segment index below one");

    // the scalar lies inside its segment whenever the divider is used
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && b_use_div_reg |-> b_num_reg < b_den_reg)
        else $error("segment offset not below segment width");

    // the dividend fits an 8-bit quotient
    assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && meta_reg[0].use_div
            |-> c_div_reg[0].rem < (pwlc_pkg::NUM_W'(c_div_reg[0].dvs) << pwlc_pkg::QUO_W))
        else $error("dividend out of quotient range");

endmodule
